@@ rtl/tsm_pkg.sv @@
// ----------------------------------------------------------------------------
// tsm_pkg
// Types and constants of the turn maneuver sequencer.
// ----------------------------------------------------------------------------
package tsm_pkg;

    localparam int DIST_W = 14;
    localparam int TICK_W = 9;
    localparam int CNT_W  = 8;
    localparam int COOL_W = 4;
    localparam int ANG_W  = 12;
    localparam int LIN_W  = 8;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_HALT  = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        DIR_LEFT  = 2'd0,
        DIR_FRONT = 2'd1,
        DIR_RIGHT = 2'd2,
        DIR_BACK  = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        PH_ROTATE = 2'd0,
        PH_CLEAR  = 2'd1,
        PH_DONE   = 2'd2,
        PH_SPARE  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RUN  = 2'd1,
        ST_DONE = 2'd2,
        ST_RSVD = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OPEN_THR    = 3'd0,
        CFG_ROT_EXIT    = 3'd1,
        CFG_CLR_STOP    = 3'd2,
        CFG_ROT_MIN     = 3'd3,
        CFG_CLR_MAX     = 3'd4,
        CFG_TIMEOUT     = 3'd5,
        CFG_COOLDOWN    = 3'd6,
        CFG_UNUSED      = 3'd7
    } cfg_idx_t;

    localparam logic signed [ANG_W-1:0] RATE_LEFT  = 12'sd1000;
    localparam logic signed [ANG_W-1:0] RATE_RIGHT = -12'sd1000;
    localparam logic signed [ANG_W-1:0] RATE_BACK  = 12'sd1600;
    localparam logic [LIN_W-1:0]        CLEAR_SPEED = 8'd250;
    localparam logic [TICK_W-1:0]       TICK_MAX    = 9'd511;

    typedef struct packed {
        logic [COOL_W-1:0]       cooldown_left;
        logic                    turning;
        status_t                 status;
        dir_t                    heading_choice;
        logic [LIN_W-1:0]        linear_mm_s;
        logic signed [ANG_W-1:0] angular_mrad_s;
    } result_t;

endpackage

@@ rtl/turn_maneuver_sequencer.sv @@
// ----------------------------------------------------------------------------
// turn_maneuver_sequencer
// Picks a turn direction on start, then steps rotate and clearance phases on
// each tick, producing rate and speed commands with a cooldown after finish.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tuser action, s_tdata distances
//  m_      | out | m_tvalid/m_tready  | m_tdata command and status
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One item per cycle sustained while m_ does not stall; an item transferred on s_
//  reaches m_ through the input register, then the result register.
//  Sequencer state is updated as an item moves into the result register.
//  A stall on m_ holds both stages; s_tready drops only when both are full.
//  aresetn is synchronous, active low; cfg_ready is always high.
// ----------------------------------------------------------------------------
module turn_maneuver_sequencer
    import tsm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // front_mm[13:0], left_mm[27:14], right_mm[41:28]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // angular_mrad_s[11:0], linear_mm_s[19:12],
                                   // heading_choice[21:20], status[23:22],
                                   // turning[24], cooldown_left[28:25]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIST_W-1:0]    cfg_data
);

    // configuration
    logic [DIST_W-1:0] open_thr_reg, rot_exit_reg, clr_stop_reg;
    logic [CNT_W-1:0]  rot_min_reg, clr_max_reg, timeout_reg;
    logic [COOL_W-1:0] cool_ticks_reg;

    // input stage
    logic              in_valid_reg;
    action_t           in_action_reg;
    logic [DIST_W-1:0] in_front_reg, in_left_reg, in_right_reg;

    // sequencer state
    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    dir_t              dir_reg, dir_next;
    logic              busy_reg, busy_next;
    logic [COOL_W-1:0] cool_reg, cool_next;

    // result stage
    logic              out_valid_reg;
    result_t           out_reg, out_next;

    logic advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {3'b000, out_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_thr_reg   <= 14'd1200;
            rot_exit_reg   <= 14'd1000;
            clr_stop_reg   <= 14'd300;
            rot_min_reg    <= 8'd8;
            clr_max_reg    <= 8'd15;
            timeout_reg    <= 8'd150;
            cool_ticks_reg <= 4'd10;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_OPEN_THR: open_thr_reg   <= cfg_data;
                CFG_ROT_EXIT: rot_exit_reg   <= cfg_data;
                CFG_CLR_STOP: clr_stop_reg   <= cfg_data;
                CFG_ROT_MIN:  rot_min_reg    <= cfg_data[CNT_W-1:0];
                CFG_CLR_MAX:  clr_max_reg    <= cfg_data[CNT_W-1:0];
                CFG_TIMEOUT:  timeout_reg    <= cfg_data[CNT_W-1:0];
                CFG_COOLDOWN: cool_ticks_reg <= cfg_data[COOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_action_reg <= action_t'(s_tuser);
            in_front_reg  <= s_tdata[13:0];
            in_left_reg   <= s_tdata[27:14];
            in_right_reg  <= s_tdata[41:28];
        end
    end

    always_comb begin
        phase_t            ph;
        logic [TICK_W-1:0] tc;
        logic              rot_exit;

        ph        = phase_reg;
        tc        = tick_reg;
        rot_exit  = 1'b0;
        dir_next  = dir_reg;
        busy_next = busy_reg;
        cool_next = cool_reg;
        out_next.angular_mrad_s = '0;
        out_next.linear_mm_s    = '0;
        out_next.status         = ST_IDLE;

        case (in_action_reg)
            ACT_START: begin
                if (in_left_reg > open_thr_reg)
                    dir_next = DIR_LEFT;
                else if (in_front_reg > open_thr_reg)
                    dir_next = DIR_FRONT;
                else if (in_right_reg > open_thr_reg)
                    dir_next = DIR_RIGHT;
                else
                    dir_next = DIR_BACK;
                busy_next = 1'b1;
                ph        = PH_ROTATE;
                tc        = '0;
                out_next.status = ST_RUN;
            end
            ACT_HALT: begin
                busy_next = 1'b0;
            end
            ACT_TICK: begin
                if (cool_reg != '0)
                    cool_next = cool_reg - 1'b1;
                if (busy_reg) begin
                    if (phase_reg == PH_ROTATE) begin
                        case (dir_reg)
                            DIR_LEFT:  out_next.angular_mrad_s = RATE_LEFT;
                            DIR_RIGHT: out_next.angular_mrad_s = RATE_RIGHT;
                            DIR_BACK:  out_next.angular_mrad_s = RATE_BACK;
                            default:   ph = PH_CLEAR;
                        endcase
                        rot_exit = (tick_reg > {1'b0, rot_min_reg}) &&
                                   (in_front_reg > rot_exit_reg);
                        if (rot_exit) begin
                            ph = PH_CLEAR;
                            tc = '0;
                        end
                    end else if (phase_reg == PH_CLEAR) begin
                        out_next.linear_mm_s = CLEAR_SPEED;
                        if (tick_reg > {1'b0, clr_max_reg} || in_front_reg < clr_stop_reg)
                            ph = PH_DONE;
                    end
                    if (tc != TICK_MAX)
                        tc = tc + 1'b1;
                    // finish on end of clearance, a stray phase, or timeout
                    if (ph == PH_DONE || ph == PH_SPARE || tc > {1'b0, timeout_reg}) begin
                        busy_next = 1'b0;
                        cool_next = cool_ticks_reg;
                        out_next.status = ST_DONE;
                    end else begin
                        out_next.status = ST_RUN;
                    end
                end
            end
            default: begin
                out_next.status = busy_reg ? ST_RUN : ST_IDLE;
            end
        endcase

        phase_next = ph;
        tick_next  = tc;
        out_next.heading_choice = dir_next;
        out_next.turning        = busy_next;
        out_next.cooldown_left  = cool_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_ROTATE;
            tick_reg  <= '0;
            dir_reg   <= DIR_LEFT;
            busy_reg  <= 1'b0;
            cool_reg  <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            dir_reg   <= dir_next;
            busy_reg  <= busy_next;
            cool_reg  <= cool_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance)
            out_reg <= out_next;
    end

`ifndef SYNTHESIS
    a_done_clears_turning: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.status == ST_DONE |-> !out_reg.turning)
        else $error("finished result still reports turning");

    a_run_means_turning: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.status == ST_RUN |-> out_reg.turning)
        else $error("running result without turning flag");

    a_speed_needs_maneuver: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_reg.linear_mm_s != '0 || out_reg.angular_mrad_s != '0)
        |-> out_reg.status != ST_IDLE)
        else $error("motion commanded while idle");

    a_busy_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (phase_reg == PH_ROTATE || phase_reg == PH_CLEAR))
        else $error("busy with finished phase");

    a_stall_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(tick_reg) && $stable(busy_reg) && $stable(cool_reg))
        else $error("sequencer state moved without an item");
`endif

endmodule
